// File: hw/rtl/rglc_pkg.sv
// rglc_pkg: shared types, codes and timer helpers for the radar gesture level controller
// used by rglc_cfg, rglc_core and radar_gesture_level_controller; depends on nothing

package rglc_pkg;

    localparam int TIMER_BITS = 16;
    localparam int CFG_BITS   = 16;
    localparam int CMP_BITS   = (TIMER_BITS > CFG_BITS) ? TIMER_BITS : CFG_BITS;
    localparam int LEVEL_BITS = 7;
    localparam int COUNT_BITS = 3;
    localparam int INDEX_BITS = 3;

    localparam logic [TIMER_BITS-1:0] TIMER_MAX = {TIMER_BITS{1'b1}};
    localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};

    typedef enum logic [2:0] {
        MODE_STANDBY = 3'd0,
        MODE_GESTURE = 3'd1,
        MODE_SETTLE  = 3'd2,
        MODE_COMMAND = 3'd3,
        MODE_EXIT    = 3'd4
    } mode_t;

    typedef enum logic [1:0] {
        LED_OFF   = 2'd0,
        LED_RED   = 2'd1,
        LED_BLUE  = 2'd2,
        LED_GREEN = 2'd3
    } led_t;

    typedef enum logic [1:0] {
        DIR_NONE     = 2'd0,
        DIR_APPROACH = 2'd1,
        DIR_DEPART   = 2'd2,
        DIR_BAD      = 2'd3
    } dir_t;

    typedef enum logic [INDEX_BITS-1:0] {
        CFG_GESTURE_WINDOW = 3'd0,
        CFG_CHANGES_NEEDED = 3'd1,
        CFG_SETTLE_TICKS   = 3'd2,
        CFG_GATING_TICKS   = 3'd3,
        CFG_UPDATE_PERIOD  = 3'd4,
        CFG_LEVEL_STEP     = 3'd5,
        CFG_LEVEL_MIN      = 3'd6,
        CFG_LEVEL_MAX      = 3'd7
    } cfg_idx_t;

    typedef struct packed {
        logic [CFG_BITS-1:0]   gesture_window;
        logic [COUNT_BITS-1:0] changes_needed;
        logic [CFG_BITS-1:0]   settle_ticks;
        logic [CFG_BITS-1:0]   gating_ticks;
        logic [CFG_BITS-1:0]   update_period;
        logic [LEVEL_BITS-1:0] level_step;
        logic [LEVEL_BITS-1:0] level_min;
        logic [LEVEL_BITS-1:0] level_max;
    } cfg_t;

    typedef struct packed {
        logic       motion_seen;
        logic [1:0] dir_code;
        logic       sample_ok;
    } item_t;

    typedef struct packed {
        mode_t                 mode;
        led_t                  led_colour;
        logic [LEVEL_BITS-1:0] level;
        logic                  exit_pulse;
    } res_t;

    // saturating tick counter
    function automatic logic [TIMER_BITS-1:0] tinc(input logic [TIMER_BITS-1:0] t);
        tinc = (t == TIMER_MAX) ? t : t + TIMER_BITS'(1);
    endfunction

    function automatic logic timer_gt(input logic [TIMER_BITS-1:0] t,
                                      input logic [CFG_BITS-1:0] c);
        timer_gt = CMP_BITS'(t) > CMP_BITS'(c);
    endfunction

    function automatic logic timer_ge(input logic [TIMER_BITS-1:0] t,
                                      input logic [CFG_BITS-1:0] c);
        timer_ge = CMP_BITS'(t) >= CMP_BITS'(c);
    endfunction

endpackage

// File: hw/rtl/rglc_cfg.sv
// rglc_cfg: configuration register bank, written one word at a time by index
// depends on rglc_pkg

module rglc_cfg (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            wr_en,
    input  logic [rglc_pkg::INDEX_BITS-1:0] wr_index,
    input  logic [rglc_pkg::CFG_BITS-1:0]   wr_data,
    output rglc_pkg::cfg_t                  cfg
);

    rglc_pkg::cfg_t cfg_reg;
    rglc_pkg::cfg_t cfg_next;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            unique case (rglc_pkg::cfg_idx_t'(wr_index))
                rglc_pkg::CFG_GESTURE_WINDOW: cfg_next.gesture_window = wr_data;
                rglc_pkg::CFG_CHANGES_NEEDED:
                    cfg_next.changes_needed = wr_data[rglc_pkg::COUNT_BITS-1:0];
                rglc_pkg::CFG_SETTLE_TICKS:   cfg_next.settle_ticks = wr_data;
                rglc_pkg::CFG_GATING_TICKS:   cfg_next.gating_ticks = wr_data;
                rglc_pkg::CFG_UPDATE_PERIOD:  cfg_next.update_period = wr_data;
                rglc_pkg::CFG_LEVEL_STEP:
                    cfg_next.level_step = wr_data[rglc_pkg::LEVEL_BITS-1:0];
                rglc_pkg::CFG_LEVEL_MIN:
                    cfg_next.level_min = wr_data[rglc_pkg::LEVEL_BITS-1:0];
                rglc_pkg::CFG_LEVEL_MAX:
                    cfg_next.level_max = wr_data[rglc_pkg::LEVEL_BITS-1:0];
                default: cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.gesture_window <= rglc_pkg::CFG_BITS'(500);
            cfg_reg.changes_needed <= rglc_pkg::COUNT_BITS'(4);
            cfg_reg.settle_ticks   <= rglc_pkg::CFG_BITS'(1000);
            cfg_reg.gating_ticks   <= rglc_pkg::CFG_BITS'(500);
            cfg_reg.update_period  <= rglc_pkg::CFG_BITS'(100);
            cfg_reg.level_step     <= rglc_pkg::LEVEL_BITS'(10);
            cfg_reg.level_min      <= rglc_pkg::LEVEL_BITS'(5);
            cfg_reg.level_max      <= rglc_pkg::LEVEL_BITS'(100);
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

// File: hw/rtl/rglc_core.sv
// rglc_core: mode sequencer, timers and level ramp; one sample word per step strobe
// depends on rglc_pkg

module rglc_core (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 step,
    input  rglc_pkg::item_t      item,
    input  rglc_pkg::cfg_t       cfg,
    output rglc_pkg::res_t       res
);

    localparam int TB = rglc_pkg::TIMER_BITS;
    localparam int LB = rglc_pkg::LEVEL_BITS;
    localparam int CB = rglc_pkg::COUNT_BITS;

    rglc_pkg::mode_t mode_reg, mode_next;
    logic [CB-1:0]   change_count_reg, change_count_next;
    logic [TB-1:0]   window_timer_reg, window_timer_next;
    logic [TB-1:0]   settle_timer_reg, settle_timer_next;
    logic [TB-1:0]   command_elapsed_reg, command_elapsed_next;
    logic [TB-1:0]   update_elapsed_reg, update_elapsed_next;
    logic [1:0]      last_direction_reg, last_direction_next;
    logic [LB-1:0]   level_reg, level_next;

    logic [1:0]      dir_cur;
    logic            dir_change;
    logic [TB-1:0]   window_inc;
    logic [TB-1:0]   settle_inc;
    logic [TB-1:0]   command_inc;
    logic [TB-1:0]   update_inc;
    logic            gate_open;
    logic            leave;
    logic [LB:0]     level_up;
    logic [LB:0]     level_floor;
    logic [CB-1:0]   count_bumped;
    logic            pulse;

    // an invalid sample or direction code three keeps the previous direction
    assign dir_cur = (item.sample_ok && item.dir_code != rglc_pkg::DIR_BAD)
                     ? item.dir_code : last_direction_reg;
    assign dir_change  = dir_cur != last_direction_reg;
    assign window_inc  = rglc_pkg::tinc(window_timer_reg);
    assign settle_inc  = rglc_pkg::tinc(settle_timer_reg);
    assign command_inc = rglc_pkg::tinc(command_elapsed_reg);
    assign update_inc  = rglc_pkg::tinc(update_elapsed_reg);
    assign gate_open   = rglc_pkg::timer_gt(command_inc, cfg.gating_ticks);
    assign leave       = gate_open && dir_change;
    assign level_up    = {1'b0, level_reg} + {1'b0, cfg.level_step};
    assign level_floor = {1'b0, cfg.level_min} + {1'b0, cfg.level_step};
    assign count_bumped = (dir_change && change_count_reg != rglc_pkg::COUNT_MAX)
                          ? change_count_reg + CB'(1) : change_count_reg;

    always_comb
    begin
        mode_next            = mode_reg;
        change_count_next    = change_count_reg;
        window_timer_next    = window_timer_reg;
        settle_timer_next    = settle_timer_reg;
        command_elapsed_next = command_elapsed_reg;
        update_elapsed_next  = update_inc;
        last_direction_next  = last_direction_reg;
        level_next           = level_reg;
        pulse                = 1'b0;

        unique case (mode_reg)
            rglc_pkg::MODE_STANDBY:
            begin
                if (item.sample_ok && item.motion_seen)
                begin
                    mode_next         = rglc_pkg::MODE_GESTURE;
                    change_count_next = '0;
                    window_timer_next = '0;
                end
            end
            rglc_pkg::MODE_GESTURE:
            begin
                last_direction_next = dir_cur;
                change_count_next   = count_bumped;
                window_timer_next   = window_inc;
                // window expiry wins over a completed gesture
                if (rglc_pkg::timer_gt(window_inc, cfg.gesture_window))
                begin
                    change_count_next = '0;
                    window_timer_next = '0;
                end
                else if (count_bumped >= cfg.changes_needed)
                begin
                    mode_next         = rglc_pkg::MODE_SETTLE;
                    settle_timer_next = '0;
                end
            end
            rglc_pkg::MODE_SETTLE:
            begin
                settle_timer_next = settle_inc;
                if (rglc_pkg::timer_ge(settle_inc, cfg.settle_ticks))
                begin
                    mode_next            = rglc_pkg::MODE_COMMAND;
                    command_elapsed_next = '0;
                end
            end
            rglc_pkg::MODE_COMMAND:
            begin
                command_elapsed_next = command_inc;
                // direction tracking only starts once gating has passed
                if (gate_open)
                    last_direction_next = dir_cur;
                if (leave)
                begin
                    mode_next         = rglc_pkg::MODE_EXIT;
                    settle_timer_next = '0;
                    pulse             = 1'b1;
                end
                else if (rglc_pkg::timer_gt(update_inc, cfg.update_period))
                begin
                    update_elapsed_next = '0;
                    if (item.sample_ok)
                    begin
                        if (item.dir_code == rglc_pkg::DIR_DEPART)
                        begin
                            if (level_reg < cfg.level_max)
                                level_next = (level_up > {1'b0, cfg.level_max})
                                             ? cfg.level_max : level_up[LB-1:0];
                        end
                        else if (level_reg > cfg.level_min)
                        begin
                            level_next = ({1'b0, level_reg} < level_floor)
                                         ? cfg.level_min : level_reg - cfg.level_step;
                        end
                    end
                end
            end
            rglc_pkg::MODE_EXIT:
            begin
                settle_timer_next = settle_inc;
                if (rglc_pkg::timer_ge(settle_inc, cfg.settle_ticks))
                    mode_next = rglc_pkg::MODE_STANDBY;
            end
            default: mode_next = rglc_pkg::MODE_STANDBY;
        endcase
    end

    always_comb
    begin
        res.mode       = mode_next;
        res.level      = level_next;
        res.exit_pulse = pulse;
        unique case (mode_next)
            rglc_pkg::MODE_GESTURE: res.led_colour = rglc_pkg::LED_RED;
            rglc_pkg::MODE_SETTLE:  res.led_colour = rglc_pkg::LED_BLUE;
            rglc_pkg::MODE_COMMAND: res.led_colour = rglc_pkg::LED_GREEN;
            default:                res.led_colour = rglc_pkg::LED_OFF;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg            <= rglc_pkg::MODE_STANDBY;
            change_count_reg    <= '0;
            window_timer_reg    <= '0;
            settle_timer_reg    <= '0;
            command_elapsed_reg <= '0;
            update_elapsed_reg  <= rglc_pkg::TIMER_MAX;
            last_direction_reg  <= rglc_pkg::DIR_NONE;
            level_reg           <= '0;
        end
        else if (step)
        begin
            mode_reg            <= mode_next;
            change_count_reg    <= change_count_next;
            window_timer_reg    <= window_timer_next;
            settle_timer_reg    <= settle_timer_next;
            command_elapsed_reg <= command_elapsed_next;
            update_elapsed_reg  <= update_elapsed_next;
            last_direction_reg  <= last_direction_next;
            level_reg           <= level_next;
        end
    end

    a_pulse_on_exit: assert property (@(posedge clk) disable iff (!rst_n)
        res.exit_pulse |-> (mode_reg == rglc_pkg::MODE_COMMAND
                            && mode_next == rglc_pkg::MODE_EXIT))
        else $error("exit pulse outside a command to exit transition");

    a_level_only_in_command: assert property (@(posedge clk) disable iff (!rst_n)
        (step && level_next != level_reg) |-> mode_reg == rglc_pkg::MODE_COMMAND)
        else $error("level moved outside command mode");

    a_gesture_start_clean: assert property (@(posedge clk) disable iff (!rst_n)
        (step && mode_reg == rglc_pkg::MODE_STANDBY
         && mode_next == rglc_pkg::MODE_GESTURE)
        |=> (change_count_reg == '0 && window_timer_reg == '0))
        else $error("gesture capture did not start from a cleared count");

    a_hold_without_step: assert property (@(posedge clk) disable iff (!rst_n)
        !step |=> ($stable(mode_reg) && $stable(level_reg)
                   && $stable(update_elapsed_reg)))
        else $error("state moved without a sample word");

endmodule

// File: hw/rtl/radar_gesture_level_controller.sv
// radar_gesture_level_controller: top level with input and result registers around the core
// depends on rglc_pkg, rglc_cfg, rglc_core
//
// Usage: one sample word (motion_seen, dir_code, sample_ok) per millisecond tick on
// the in channel; each word yields exactly one result word (mode, led_colour, level,
// exit_pulse) on the out channel, in order. Both channels use valid/ready.
// The cfg channel writes register cfg_index with cfg_data; it is always ready and
// should be used only while no word is in flight.
// Path: an accepted word goes from the input register through rglc_core into the
// result register and is shown on out with out_valid high. Throughput: one word per
// cycle while out is not stalled, set by the state update in rglc_core between them.
// Stall: while out_ready is low the result word holds; the input register still
// takes one more word, then in_ready drops until the result is taken.
// Reset: rst_n clears both registers' valid flags, puts the mode to standby with
// level zero and loads the default configuration.

module radar_gesture_level_controller (
    input  logic                            clk,
    input  logic                            rst_n,

    input  logic                            in_valid,
    output logic                            in_ready,
    input  logic                            motion_seen,
    input  logic [1:0]                      dir_code,
    input  logic                            sample_ok,

    output logic                            out_valid,
    input  logic                            out_ready,
    output logic [2:0]                      mode,
    output logic [1:0]                      led_colour,
    output logic [rglc_pkg::LEVEL_BITS-1:0] level,
    output logic                            exit_pulse,

    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [rglc_pkg::INDEX_BITS-1:0] cfg_index,
    input  logic [rglc_pkg::CFG_BITS-1:0]   cfg_data
);

    rglc_pkg::cfg_t  cfg;
    rglc_pkg::item_t item_reg;
    rglc_pkg::res_t  res;
    rglc_pkg::res_t  res_reg;
    logic            in_full_reg;
    logic            out_full_reg;
    logic            advance;
    logic            in_take;

    assign cfg_ready = 1'b1;
    assign advance   = in_full_reg && (!out_full_reg || out_ready);
    assign in_ready  = !in_full_reg || advance;
    assign in_take   = in_valid && in_ready;

    rglc_cfg u_cfg (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_en    (cfg_valid && cfg_ready),
        .wr_index (cfg_index),
        .wr_data  (cfg_data),
        .cfg      (cfg)
    );

    rglc_core u_core (
        .clk   (clk),
        .rst_n (rst_n),
        .step  (advance),
        .item  (item_reg),
        .cfg   (cfg),
        .res   (res)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_full_reg  <= 1'b0;
            out_full_reg <= 1'b0;
        end
        else
        begin
            if (in_take)
                in_full_reg <= 1'b1;
            else if (advance)
                in_full_reg <= 1'b0;

            if (advance)
                out_full_reg <= 1'b1;
            else if (out_ready)
                out_full_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            item_reg.motion_seen <= motion_seen;
            item_reg.dir_code    <= dir_code;
            item_reg.sample_ok   <= sample_ok;
        end
        if (advance)
            res_reg <= res;
    end

    assign out_valid  = out_full_reg;
    assign mode       = res_reg.mode;
    assign led_colour = res_reg.led_colour;
    assign level      = res_reg.level;
    assign exit_pulse = res_reg.exit_pulse;

endmodule
